// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/jst_pkg.sv -----
package jst_pkg;

  // Defaults for the top-level parameter and the length register.
  localparam int POSITION_BITS_DEF = 16;
  localparam logic [7:0] MAX_TEXT_LEN_RST = 8'd31;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  // Token kinds.
  localparam logic [3:0] KIND_LBRACE = 4'd0;
  localparam logic [3:0] KIND_RBRACE = 4'd1;
  localparam logic [3:0] KIND_COLON  = 4'd2;
  localparam logic [3:0] KIND_COMMA  = 4'd3;
  localparam logic [3:0] KIND_SCHAR  = 4'd4;
  localparam logic [3:0] KIND_SEND   = 4'd5;
  localparam logic [3:0] KIND_DIGIT  = 4'd6;
  localparam logic [3:0] KIND_NEND   = 4'd7;
  localparam logic [3:0] KIND_EOF    = 4'd8;
  localparam logic [3:0] KIND_ERROR  = 4'd9;

  // Error codes.
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_UNTERM  = 3'd1;
  localparam logic [2:0] ERR_ESCAPE  = 3'd2;
  localparam logic [2:0] ERR_STRLONG = 3'd3;
  localparam logic [2:0] ERR_NUMLONG = 3'd4;
  localparam logic [2:0] ERR_UNEXP   = 3'd5;

  // Characters the lexer recognizes.
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // One result beat.
  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  text;
    logic [31:0] value;
    logic        ovf;
    logic [2:0]  err;
    logic [15:0] pos;
    logic        last;
  } res_t;

  // Up to two results produced by one lexed beat.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } lex_out_t;

  function automatic res_t mk_res(input logic [3:0] kind, input logic [7:0] text,
                                  input logic [31:0] value, input logic ovf,
                                  input logic [2:0] err, input logic [15:0] pos);
    res_t r;
    r.kind  = kind;
    r.text  = text;
    r.value = value;
    r.ovf   = ovf;
    r.err   = err;
    r.pos   = pos;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

// ----- rtl/jst_lexer.sv -----
module jst_lexer #(
  parameter int POSITION_BITS = jst_pkg::POSITION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              action,
  input  logic [7:0]        data_byte,
  input  logic [7:0]        max_text_len,
  output jst_pkg::lex_out_t lex_out
);
  import jst_pkg::*;

  localparam int PW = POSITION_BITS;
  localparam logic [PW-1:0] POS_MAX = '1;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_STRING = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;
  localparam logic [1:0] MODE_ERROR  = 2'd3;

  logic [1:0]    mode_r, mode_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic          ovf_r, ovf_nxt;
  logic [PW-1:0] pos_r, pos_nxt;

  logic [PW+15:0] pos_ext;
  logic [15:0]    pos16;
  logic           is_digit;
  logic [35:0]    sum36;
  logic           acc_hit;
  logic [31:0]    acc_step;

  logic       idl_n;
  res_t       idl_res;
  logic [1:0] idl_mode;
  logic [7:0] idl_len;
  logic [31:0] idl_acc;
  logic       idl_ovf;

  res_t       r0, r1;
  logic [1:0] n;

  // Error offsets are reported saturated to 16 bits.
  assign pos_ext = {16'b0, pos_r};
  assign pos16   = (|pos_ext[PW+15:16]) ? 16'hFFFF : pos_ext[15:0];

  assign is_digit = data_byte inside {[CH_ZERO:CH_NINE]};

  // Next accumulator value: acc * 10 + digit, saturating on a carry past 32 bits.
  assign sum36    = {1'b0, acc_r, 3'b0} + {3'b0, acc_r, 1'b0} + {32'b0, data_byte[3:0]};
  assign acc_hit  = |sum36[35:32];
  assign acc_step = acc_hit ? 32'hFFFF_FFFF : sum36[31:0];

  // Decode of a byte seen between tokens; also used for the byte that ends a number.
  always_comb begin
    idl_n    = 1'b0;
    idl_res  = '0;
    idl_mode = MODE_IDLE;
    idl_len  = len_r;
    idl_acc  = acc_r;
    idl_ovf  = ovf_r;
    case (data_byte)
      CH_SPACE, CH_TAB, CH_CR, CH_LF: idl_n = 1'b0;
      CH_LBRACE: begin
        idl_n   = 1'b1;
        idl_res = mk_res(KIND_LBRACE, 8'd0, 32'd0, 1'b0, ERR_NONE, 16'd0);
      end
      CH_RBRACE: begin
        idl_n   = 1'b1;
        idl_res = mk_res(KIND_RBRACE, 8'd0, 32'd0, 1'b0, ERR_NONE, 16'd0);
      end
      CH_COLON: begin
        idl_n   = 1'b1;
        idl_res = mk_res(KIND_COLON, 8'd0, 32'd0, 1'b0, ERR_NONE, 16'd0);
      end
      CH_COMMA: begin
        idl_n   = 1'b1;
        idl_res = mk_res(KIND_COMMA, 8'd0, 32'd0, 1'b0, ERR_NONE, 16'd0);
      end
      CH_QUOTE: begin
        idl_mode = MODE_STRING;
        idl_len  = 8'd0;
      end
      default: begin
        idl_n = 1'b1;
        if (is_digit) begin
          idl_mode = MODE_NUMBER;
          idl_len  = 8'd1;
          idl_acc  = {28'b0, data_byte[3:0]};
          idl_ovf  = 1'b0;
          idl_res  = mk_res(KIND_DIGIT, data_byte, 32'd0, 1'b0, ERR_NONE, 16'd0);
        end else begin
          idl_mode = MODE_ERROR;
          idl_res  = mk_res(KIND_ERROR, 8'd0, 32'd0, 1'b0, ERR_UNEXP, pos16);
        end
      end
    endcase
  end

  // Main lexer step for one beat.
  always_comb begin
    mode_nxt = mode_r;
    len_nxt  = len_r;
    acc_nxt  = acc_r;
    ovf_nxt  = ovf_r;
    pos_nxt  = pos_r;
    n        = 2'd0;
    r0       = '0;
    r1       = '0;
    if (action) begin
      // End of document: close any open token, then eof.
      case (mode_r)
        MODE_STRING: begin
          n  = 2'd2;
          r0 = mk_res(KIND_ERROR, 8'd0, 32'd0, 1'b0, ERR_UNTERM, pos16);
          r1 = mk_res(KIND_EOF, 8'd0, 32'd0, 1'b0, ERR_NONE, 16'd0);
        end
        MODE_NUMBER: begin
          n  = 2'd2;
          r0 = mk_res(KIND_NEND, 8'd0, acc_r, ovf_r, ERR_NONE, 16'd0);
          r1 = mk_res(KIND_EOF, 8'd0, 32'd0, 1'b0, ERR_NONE, 16'd0);
        end
        default: begin
          n  = 2'd1;
          r0 = mk_res(KIND_EOF, 8'd0, 32'd0, 1'b0, ERR_NONE, 16'd0);
        end
      endcase
      mode_nxt = MODE_IDLE;
      len_nxt  = 8'd0;
      acc_nxt  = 32'd0;
      ovf_nxt  = 1'b0;
      pos_nxt  = '0;
    end else begin
      if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + 1'b1;
      end
      case (mode_r)
        MODE_IDLE: begin
          n        = {1'b0, idl_n};
          r0       = idl_res;
          mode_nxt = idl_mode;
          len_nxt  = idl_len;
          acc_nxt  = idl_acc;
          ovf_nxt  = idl_ovf;
        end
        MODE_STRING: begin
          n = 2'd1;
          if (data_byte == CH_QUOTE) begin
            mode_nxt = MODE_IDLE;
            r0 = mk_res(KIND_SEND, 8'd0, 32'd0, 1'b0, ERR_NONE, 16'd0);
          end else if (data_byte == CH_BSLASH) begin
            mode_nxt = MODE_ERROR;
            r0 = mk_res(KIND_ERROR, 8'd0, 32'd0, 1'b0, ERR_ESCAPE, pos16);
          end else if (len_r >= max_text_len) begin
            mode_nxt = MODE_ERROR;
            r0 = mk_res(KIND_ERROR, 8'd0, 32'd0, 1'b0, ERR_STRLONG, pos16);
          end else begin
            len_nxt = len_r + 8'd1;
            r0 = mk_res(KIND_SCHAR, data_byte, 32'd0, 1'b0, ERR_NONE, 16'd0);
          end
        end
        MODE_NUMBER: begin
          if (is_digit) begin
            n = 2'd1;
            if (len_r >= max_text_len) begin
              mode_nxt = MODE_ERROR;
              r0 = mk_res(KIND_ERROR, 8'd0, 32'd0, 1'b0, ERR_NUMLONG, pos16);
            end else begin
              acc_nxt = acc_step;
              ovf_nxt = ovf_r | acc_hit;
              len_nxt = len_r + 8'd1;
              r0 = mk_res(KIND_DIGIT, data_byte, 32'd0, 1'b0, ERR_NONE, 16'd0);
            end
          end else begin
            // The terminating byte closes the number and is lexed on its own.
            n        = 2'd1 + {1'b0, idl_n};
            r0       = mk_res(KIND_NEND, 8'd0, acc_r, ovf_r, ERR_NONE, 16'd0);
            r1       = idl_res;
            mode_nxt = idl_mode;
            len_nxt  = idl_len;
            acc_nxt  = idl_acc;
            ovf_nxt  = idl_ovf;
          end
        end
        default: n = 2'd0;
      endcase
    end
    // Flag the final result of the beat.
    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  assign lex_out.n  = n;
  assign lex_out.r0 = r0;
  assign lex_out.r1 = r1;

  // Lexer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      len_r  <= 8'd0;
      acc_r  <= 32'd0;
      ovf_r  <= 1'b0;
      pos_r  <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      acc_r  <= acc_nxt;
      ovf_r  <= ovf_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

// ----- rtl/jst_out_fifo.sv -----
module jst_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_en,
  input  jst_pkg::lex_out_t push,
  input  logic              pop,
  output jst_pkg::res_t     head,
  output logic              not_empty,
  output logic              room
);
  import jst_pkg::*;

  res_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic [1:0]         n_push;
  logic               pop_fire;
  logic [FIFO_AW-1:0] wr_ptr_p1;

  assign n_push    = push_en ? push.n : 2'd0;
  assign not_empty = (cnt_r != '0);
  assign pop_fire  = pop && not_empty;
  // Two free entries are needed, since one beat can yield two results.
  assign room      = (cnt_r <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
  assign head      = mem_r[rd_ptr_r];
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + n_push[FIFO_AW-1:0];
    rd_ptr_nxt = rd_ptr_r + {{(FIFO_AW-1){1'b0}}, pop_fire};
    cnt_nxt    = cnt_r + {{(FIFO_AW-1){1'b0}}, n_push} - {{FIFO_AW{1'b0}}, pop_fire};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Result storage; entries carry no reset.
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.r1;
    end
  end

endmodule

// ----- rtl/json_subset_tokenizer.sv -----
// A byte beat accepted into the input register is lexed once the result queue has room for two
// results; its results are written to the queue as it is lexed and leave it by the result port.
// Throughput: one input beat per cycle while each beat yields at most one result and out_stall
// stays low; the result port delivers one beat per cycle, so bytes with two results slow the input.
// A four-entry result queue separates the lexer from the result port's stall.
// Reset (rst_n low, synchronous) clears the lexer state, the queue and sets max_text_len to 31.
module json_subset_tokenizer #(
  parameter int POSITION_BITS = jst_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_kind,
  output logic [7:0]  out_text_byte,
  output logic [31:0] out_number_value,
  output logic        out_number_overflow,
  output logic [2:0]  out_error_code,
  output logic [15:0] out_error_position,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_max_text_len
);
  import jst_pkg::*;

  logic       in_vld_r;
  logic       in_action_r;
  logic [7:0] in_byte_r;
  logic [7:0] max_len_r;
  logic       step;
  logic       room;
  logic       in_fire;
  lex_out_t   lex_out;
  res_t       head;

  // The registered beat is lexed when the queue can take two results.
  assign step     = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign in_fire  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_fire || step) begin
      in_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_action_r <= in_action;
      in_byte_r   <= in_data_byte;
    end
  end

  // Length limit register, written while nothing is in flight.
  assign cfg_ready = !in_vld_r && !out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_TEXT_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_max_text_len;
    end
  end

  jst_lexer #(
    .POSITION_BITS(POSITION_BITS)
  ) u_lexer (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .action      (in_action_r),
    .data_byte   (in_byte_r),
    .max_text_len(max_len_r),
    .lex_out     (lex_out)
  );

  jst_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_en  (step),
    .push     (lex_out),
    .pop      (!out_stall),
    .head     (head),
    .not_empty(out_valid),
    .room     (room)
  );

  // Result port.
  assign out_token_kind      = head.kind;
  assign out_text_byte       = head.text;
  assign out_number_value    = head.value;
  assign out_number_overflow = head.ovf;
  assign out_error_code      = head.err;
  assign out_error_position  = head.pos;
  assign out_last_of_run     = head.last;

endmodule

// ----- rtl/jst_checker.sv -----
`include "assert_macros.svh"

module jst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_token_kind,
  input logic [7:0]  out_text_byte,
  input logic [31:0] out_number_value,
  input logic        out_number_overflow,
  input logic [2:0]  out_error_code,
  input logic [15:0] out_error_position,
  input logic        out_last_of_run
);
  import jst_pkg::*;

  logic [64:0] out_beat;

  // All fields of the result beat, for the hold check.
  assign out_beat = {out_token_kind, out_text_byte, out_number_value, out_number_overflow,
                     out_error_code, out_error_position, out_last_of_run};

  // A stalled result beat stays put.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_beat))

  // Only error results carry an error code, and every error result carries one.
  `ASSERT_IMPLIES(a_err_code, clk, rst_n, out_valid, (out_token_kind == KIND_ERROR) == (out_error_code != ERR_NONE))

  // Text bytes appear only on string characters and digits.
  `ASSERT_IMPLIES(a_text_zero, clk, rst_n, out_valid && out_token_kind != KIND_SCHAR && out_token_kind != KIND_DIGIT, out_text_byte == 8'd0)

  // Value and overflow appear only on number end.
  `ASSERT_IMPLIES(a_value_zero, clk, rst_n, out_valid && out_token_kind != KIND_NEND, out_number_value == 32'd0 && !out_number_overflow)

  // End of document is always the final result of its beat.
  `ASSERT_IMPLIES(a_eof_last, clk, rst_n, out_valid && out_token_kind == KIND_EOF, out_last_of_run)

endmodule

bind json_subset_tokenizer jst_checker u_jst_checker (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import jst_pkg::*;

  // Lexer modes tracked by the prediction.
  typedef enum logic [1:0] {LEX_IDLE, LEX_STRING, LEX_NUMBER, LEX_ERROR} lex_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic [7:0]  in_data_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_token_kind;
  logic [7:0]  out_text_byte;
  logic [31:0] out_number_value;
  logic        out_number_overflow;
  logic [2:0]  out_error_code;
  logic [15:0] out_error_position;
  logic        out_last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_max_text_len = 8'd0;

  // Shadow of the lexer state and the length register.
  lex_state_t  lex_state = LEX_IDLE;
  logic [7:0]  tok_len = 8'd0;
  logic [31:0] accum = 32'd0;
  logic        ovf_seen = 1'b0;
  logic [15:0] byte_pos = 16'd0;
  logic [7:0]  max_len = MAX_TEXT_LEN_RST;

  res_t        expected_tokens[$];
  res_t        run_tokens[$];
  res_t        want_tok;
  int          mismatches = 0;
  int          beats_sent = 0;
  int          idle_odds = 3;
  int          stall_left = 0;

  json_subset_tokenizer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_token_kind     (out_token_kind),
    .out_text_byte      (out_text_byte),
    .out_number_value   (out_number_value),
    .out_number_overflow(out_number_overflow),
    .out_error_code     (out_error_code),
    .out_error_position (out_error_position),
    .out_last_of_run    (out_last_of_run),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_max_text_len   (cfg_max_text_len)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Token prediction
  // ---------------------------------------------------------------------------

  // Queue one token for the beat being lexed.
  task automatic emit(input logic [3:0] kind, input logic [7:0] text, input logic [31:0] value,
                      input logic ovf, input logic [2:0] err, input logic [15:0] pos);
    res_t t;
    t.kind  = kind;
    t.text  = text;
    t.value = value;
    t.ovf   = ovf;
    t.err   = err;
    t.pos   = pos;
    t.last  = 1'b0;
    run_tokens.push_back(t);
  endtask

  // An error is sticky until the end of the document.
  task automatic raise_error(input logic [2:0] code);
    lex_state = LEX_ERROR;
    emit(KIND_ERROR, 8'd0, 32'd0, 1'b0, code, byte_pos);
  endtask

  // Fold one decimal digit into the value, saturating on overflow.
  task automatic add_digit(input logic [7:0] c);
    logic [31:0] d;
    d = 32'(c - CH_ZERO);
    if (accum > (32'hFFFF_FFFF - d) / 32'd10) begin
      accum = 32'hFFFF_FFFF;
      ovf_seen = 1'b1;
    end else begin
      accum = accum * 32'd10 + d;
    end
    tok_len = tok_len + 8'd1;
  endtask

  task automatic close_number();
    lex_state = LEX_IDLE;
    emit(KIND_NEND, 8'd0, accum, ovf_seen, ERR_NONE, 16'd0);
  endtask

  // Lex a byte that starts a new token.
  task automatic lex_fresh(input logic [7:0] c);
    case (c)
      CH_SPACE, CH_TAB, CH_CR, CH_LF: ;
      CH_LBRACE: emit(KIND_LBRACE, 8'd0, 32'd0, 1'b0, ERR_NONE, 16'd0);
      CH_RBRACE: emit(KIND_RBRACE, 8'd0, 32'd0, 1'b0, ERR_NONE, 16'd0);
      CH_COLON:  emit(KIND_COLON, 8'd0, 32'd0, 1'b0, ERR_NONE, 16'd0);
      CH_COMMA:  emit(KIND_COMMA, 8'd0, 32'd0, 1'b0, ERR_NONE, 16'd0);
      CH_QUOTE: begin
        lex_state = LEX_STRING;
        tok_len = 8'd0;
      end
      default: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          lex_state = LEX_NUMBER;
          tok_len = 8'd0;
          accum = 32'd0;
          ovf_seen = 1'b0;
          add_digit(c);
          emit(KIND_DIGIT, c, 32'd0, 1'b0, ERR_NONE, 16'd0);
        end else begin
          raise_error(ERR_UNEXP);
        end
      end
    endcase
  endtask

  // Work out the tokens of one accepted input beat and queue them.
  task automatic predict_beat(input logic act, input logic [7:0] c);
    run_tokens.delete();
    if (act) begin
      if (lex_state == LEX_STRING) begin
        emit(KIND_ERROR, 8'd0, 32'd0, 1'b0, ERR_UNTERM, byte_pos);
      end else if (lex_state == LEX_NUMBER) begin
        close_number();
      end
      emit(KIND_EOF, 8'd0, 32'd0, 1'b0, ERR_NONE, 16'd0);
      lex_state = LEX_IDLE;
      tok_len = 8'd0;
      accum = 32'd0;
      ovf_seen = 1'b0;
      byte_pos = 16'd0;
    end else begin
      case (lex_state)
        LEX_IDLE: lex_fresh(c);
        LEX_STRING: begin
          if (c == CH_QUOTE) begin
            lex_state = LEX_IDLE;
            emit(KIND_SEND, 8'd0, 32'd0, 1'b0, ERR_NONE, 16'd0);
          end else if (c == CH_BSLASH) begin
            raise_error(ERR_ESCAPE);
          end else if (tok_len >= max_len) begin
            raise_error(ERR_STRLONG);
          end else begin
            tok_len = tok_len + 8'd1;
            emit(KIND_SCHAR, c, 32'd0, 1'b0, ERR_NONE, 16'd0);
          end
        end
        LEX_NUMBER: begin
          if (c >= CH_ZERO && c <= CH_NINE) begin
            if (tok_len >= max_len) begin
              raise_error(ERR_NUMLONG);
            end else begin
              add_digit(c);
              emit(KIND_DIGIT, c, 32'd0, 1'b0, ERR_NONE, 16'd0);
            end
          end else begin
            // The terminating byte is lexed again as a token of its own.
            close_number();
            lex_fresh(c);
          end
        end
        default: ;
      endcase
      if (byte_pos != 16'hFFFF) begin
        byte_pos = byte_pos + 16'd1;
      end
    end
    for (int i = 0; i < run_tokens.size(); i++) begin
      want_tok = run_tokens[i];
      want_tok.last = (i == run_tokens.size() - 1);
      expected_tokens.push_back(want_tok);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts and the token checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected token: expected none, actual kind %0d", $time,
                 out_token_kind);
        mismatches++;
      end else begin
        want_tok = expected_tokens.pop_front();
        check_field("token_kind", want_tok.kind, out_token_kind);
        check_field("text_byte", want_tok.text, out_text_byte);
        check_field("number_value", want_tok.value, out_number_value);
        check_field("number_overflow", want_tok.ovf, out_number_overflow);
        check_field("error_code", want_tok.err, out_error_code);
        check_field("error_position", want_tok.pos, out_error_position);
        check_field("last_of_run", want_tok.last, out_last_of_run);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Send one beat, with an occasional gap before it, and predict it once accepted.
  task automatic send_beat(input logic act, input logic [7:0] b);
    if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(act, b);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i]);
  endtask

  task automatic send_end();
    send_beat(1'b1, 8'($urandom));
  endtask

  // Drop valid and wait until every predicted token has come out.
  task automatic wait_for_results();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_tokens.size() != 0) begin
      $display("%0t: missing tokens: expected %0d more, actual 0", $time,
               expected_tokens.size());
      mismatches++;
      expected_tokens.delete();
    end
  endtask

  // Length register writes happen only with the lexer drained.
  task automatic write_max_len(input logic [7:0] v);
    wait_for_results();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_max_text_len <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    max_len = v;
  endtask

  // ---------------------------------------------------------------------------
  // Document generation
  // ---------------------------------------------------------------------------

  // Token length: mostly short, sometimes right around the limit.
  function automatic int pick_len(input int lo);
    int n;
    if ($urandom_range(0, 7) == 0) begin
      n = int'(max_len) - 1 + int'($urandom_range(0, 2));
    end else begin
      n = $urandom_range(lo, 8);
    end
    return (n < lo) ? lo : n;
  endfunction

  // Opening quote and n characters of any value but quote and backslash.
  task automatic send_string_body(input int n);
    logic [7:0] ch;
    send_beat(1'b0, CH_QUOTE);
    repeat (n) begin
      do ch = 8'($urandom); while (ch == CH_QUOTE || ch == CH_BSLASH);
      send_beat(1'b0, ch);
    end
  endtask

  task automatic send_number(input int n);
    repeat (n) send_beat(1'b0, 8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic random_piece();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      case ($urandom_range(0, 3))
        0: send_beat(1'b0, CH_LBRACE);
        1: send_beat(1'b0, CH_RBRACE);
        2: send_beat(1'b0, CH_COLON);
        default: send_beat(1'b0, CH_COMMA);
      endcase
    end else if (pick < 32) begin
      case ($urandom_range(0, 3))
        0: send_beat(1'b0, CH_SPACE);
        1: send_beat(1'b0, CH_TAB);
        2: send_beat(1'b0, CH_CR);
        default: send_beat(1'b0, CH_LF);
      endcase
    end else if (pick < 60) begin
      send_string_body(pick_len(0));
      if ($urandom_range(0, 29) == 0) send_beat(1'b0, CH_BSLASH);
      if ($urandom_range(0, 19) != 0) send_beat(1'b0, CH_QUOTE);
    end else if (pick < 90) begin
      // Values right at and beyond the 32-bit limit now and then.
      case ($urandom_range(0, 9))
        0: send_text("4294967295");
        1: send_text("4294967296");
        2: send_text("99999999999");
        default: send_number(pick_len(1));
      endcase
    end else if (pick < 97) begin
      send_beat(1'b0, 8'($urandom));
    end else begin
      send_end();
    end
  endtask

  task automatic run_documents(input int n_beats);
    int target;
    target = beats_sent + n_beats;
    while (beats_sent < target) begin
      case ($urandom_range(0, 3))
        0: idle_odds = 0;
        1: idle_odds = 1;
        2: idle_odds = 3;
        default: idle_odds = 6;
      endcase
      repeat ($urandom_range(1, 40)) begin
        if (beats_sent < target) random_piece();
      end
      send_end();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // A small well-formed object with every kind of whitespace.
  task automatic test_token_stream();
    send_text("{ \"k\"");
    send_beat(1'b0, CH_TAB);
    send_text(":");
    send_beat(1'b0, CH_CR);
    send_text("42,");
    send_beat(1'b0, CH_LF);
    send_text("}");
    send_end();
  endtask

  // Number ended by a quote, escape, sticky error, end inside number and string,
  // and a number ended by a byte that is itself illegal.
  task automatic test_error_paths();
    send_text("9\"\\z");
    send_end();
    send_text("7");
    send_end();
    send_text("\"");
    send_end();
    send_text("5@");
    send_end();
  endtask

  // Tokens exactly at and one past the limit, with the limit set to 1 and to 255.
  task automatic test_length_limits();
    logic [7:0] limits[2];
    limits[0] = 8'd1;
    limits[1] = 8'd255;
    foreach (limits[i]) begin
      write_max_len(limits[i]);
      send_string_body(limits[i]);
      send_beat(1'b0, CH_QUOTE);
      send_string_body(int'(limits[i]) + 1);
      send_end();
      send_number(limits[i]);
      send_beat(1'b0, CH_COMMA);
      send_number(int'(limits[i]) + 1);
      send_end();
      run_documents(100);
    end
  endtask

  // Random documents under a handful of random length limits.
  task automatic test_random_documents();
    repeat (4) begin
      write_max_len(8'($urandom_range(1, 255)));
      run_documents(50);
    end
    write_max_len(MAX_TEXT_LEN_RST);
    run_documents(100);
  endtask

  // Full-rate traffic with no idling on either side.
  task automatic test_back_to_back();
    int target;
    wait_for_results();
    idle_odds = 0;
    target = beats_sent + 250;
    while (beats_sent < target) begin
      repeat ($urandom_range(1, 40)) begin
        if (beats_sent < target) random_piece();
      end
      send_end();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_token_stream();
    test_error_paths();
    test_length_limits();
    test_random_documents();
    test_back_to_back();
    wait_for_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS json_subset_tokenizer");
    end else begin
      $display("FAIL json_subset_tokenizer");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #100_000_000;
    $display("FAIL json_subset_tokenizer");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/jst_pkg.sv
rtl/jst_lexer.sv
rtl/jst_out_fifo.sv
rtl/json_subset_tokenizer.sv
rtl/jst_checker.sv
sim/tb_top.sv
